>>> design/kmrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kmrd_pkg;

    // width of one matrix row as seen on the ports
    localparam int ROW_W = 16;

    localparam int ROWS_DEF   = 8;
    localparam int COLS_DEF   = 16;
    localparam int FRAMES_DEF = 4;

    typedef enum logic [1:0] {
        FUNC_SCAN    = 2'd0,
        FUNC_EXTRA   = 2'd1,
        FUNC_ONESHOT = 2'd2,
        FUNC_READ    = 2'd3
    } func_t;

    typedef logic [ROW_W-1:0] row_t;

endpackage

`default_nettype wire

>>> design/kmrd_debounce.sv
`timescale 1ns / 1ps
`default_nettype none

module kmrd_debounce #(
    parameter int FRAMES = kmrd_pkg::FRAMES_DEF
) (
    input  wire kmrd_pkg::row_t                cur,
    input  wire kmrd_pkg::row_t [FRAMES-1:0]   window,
    output kmrd_pkg::row_t                     debounced
);

    kmrd_pkg::row_t flip;

    // a key flips only when every sample in the window disagrees with it
    always_comb
    begin
        flip = '1;
        for (int k = 0; k < FRAMES; k++)
        begin
            flip = flip & (cur ^ window[k]);
        end
    end

    assign debounced = cur ^ flip;

endmodule

`default_nettype wire

>>> design/key_matrix_row_debouncer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  signals                           request contents
// s         in   s_tvalid s_tready s_tdata s_tuser  func, row, col, press, raw_cols
// m         out  m_tvalid m_tready m_tdata m_tuser  row_bits, ignored
// cfg       in   cfg_valid cfg_ready cfg_data       active_high
//
// each request is held in the input register and is resolved into the result
// register once the result register can take it; one request per cycle sustained while m_tready is high
// the state of a row is updated on the same edge the result is registered
// a stalled result register holds the input register, which then holds s_tready low
// rst_n clears all control and per-row state; sample storage is not cleared,
// the per-row fill count keeps unwritten slots out of the vote

module key_matrix_row_debouncer #(
    parameter int ROWS   = kmrd_pkg::ROWS_DEF,
    parameter int COLS   = kmrd_pkg::COLS_DEF,
    parameter int FRAMES = kmrd_pkg::FRAMES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // row[3:0], col[8:4], press[9], raw_cols[25:10], zero
    input  wire  [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // row_bits[15:0]
    output logic [0:0]  m_tuser,   // ignored[0]
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [0:0]  cfg_data   // active_high[0]
);

    localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int POS_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FILL_W = $clog2(FRAMES + 1);
    localparam logic [FILL_W-1:0] FRAMES_FILL = FILL_W'(FRAMES);
    localparam logic [POS_W:0]    FRAMES_POS  = (POS_W + 1)'(FRAMES);

    // configuration
    logic active_high_reg;

    // input register
    logic                 in_valid_reg;
    kmrd_pkg::func_t      in_func_reg;
    logic [3:0]           in_row_reg;
    logic [4:0]           in_col_reg;
    logic                 in_press_reg;
    kmrd_pkg::row_t       in_raw_reg;

    // result register
    logic                 out_valid_reg;
    kmrd_pkg::row_t       out_bits_reg;
    logic                 out_ign_reg;
    kmrd_pkg::row_t       out_bits_next;
    logic                 out_ign_next;

    // per-row state
    kmrd_pkg::row_t [FRAMES-1:0] win_reg  [ROWS];
    logic [FILL_W-1:0]           fill_reg [ROWS];
    logic [POS_W-1:0]            pos_reg  [ROWS];
    kmrd_pkg::row_t              deb_reg  [ROWS];
    kmrd_pkg::row_t              extra_reg[ROWS];
    kmrd_pkg::row_t              shot_reg [ROWS];
    logic [ROWS-1:0]             pend_reg;

    kmrd_pkg::row_t [FRAMES-1:0] win_row_next;
    logic [FILL_W-1:0]           fill_row_next;
    logic [POS_W-1:0]            pos_row_next;
    kmrd_pkg::row_t              deb_row_next;
    kmrd_pkg::row_t              extra_row_next;
    kmrd_pkg::row_t              shot_row_next;
    logic                        pend_row_next;
    logic                        row_we;

    logic                 adv;
    logic [RIDX_W-1:0]    ridx;
    logic                 row_ok;
    logic                 col_ok;
    kmrd_pkg::row_t       col_mask;
    kmrd_pkg::row_t       sample;
    kmrd_pkg::row_t       col_bit;
    kmrd_pkg::row_t       voted;
    logic [POS_W:0]       pos_inc;

    assign adv       = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_bits_reg;
    assign m_tuser   = out_ign_reg;

    // pins at or above COLS never count as pressed
    for (genvar i = 0; i < kmrd_pkg::ROW_W; i++)
    begin : g_mask
        assign col_mask[i] = (i < COLS);
    end

    assign ridx    = in_row_reg[RIDX_W-1:0];
    assign row_ok  = {1'b0, in_row_reg} < 5'(ROWS);
    assign col_ok  = ({1'b0, in_col_reg} < 6'(COLS)) && (in_col_reg < 5'(kmrd_pkg::ROW_W));
    assign sample  = (active_high_reg ? in_raw_reg : ~in_raw_reg) & col_mask;
    assign col_bit = kmrd_pkg::row_t'(1) << in_col_reg[3:0];
    assign pos_inc = {1'b0, pos_reg[ridx]} + 1'b1;

    // window of the addressed row with the new sample in the oldest slot
    always_comb
    begin
        win_row_next = win_reg[ridx];
        for (int k = 0; k < FRAMES; k++)
        begin
            if (pos_reg[ridx] == POS_W'(k))
            begin
                win_row_next[k] = sample;
            end
        end
    end

    kmrd_debounce #(
        .FRAMES (FRAMES)
    ) u_debounce (
        .cur       (deb_reg[ridx]),
        .window    (win_row_next),
        .debounced (voted)
    );

    always_comb
    begin
        fill_row_next  = fill_reg[ridx];
        pos_row_next   = pos_reg[ridx];
        deb_row_next   = deb_reg[ridx];
        extra_row_next = extra_reg[ridx];
        shot_row_next  = shot_reg[ridx];
        pend_row_next  = pend_reg[ridx];
        row_we         = 1'b0;
        out_bits_next  = '0;
        out_ign_next   = 1'b0;

        if (!row_ok)
        begin
            out_ign_next = 1'b1;
        end
        else
        begin
            case (in_func_reg)
                kmrd_pkg::FUNC_SCAN:
                begin
                    row_we       = 1'b1;
                    pos_row_next = (pos_inc >= FRAMES_POS) ? '0 : pos_inc[POS_W-1:0];
                    if (fill_reg[ridx] < FRAMES_FILL)
                    begin
                        fill_row_next = fill_reg[ridx] + 1'b1;
                    end
                    if (fill_row_next >= FRAMES_FILL)
                    begin
                        deb_row_next = voted;
                    end
                    out_bits_next = deb_row_next;
                end
                kmrd_pkg::FUNC_READ:
                begin
                    row_we        = 1'b1;
                    out_bits_next = deb_reg[ridx] | extra_reg[ridx];
                    if (pend_reg[ridx])
                    begin
                        out_bits_next = out_bits_next | shot_reg[ridx];
                        shot_row_next = '0;
                        pend_row_next = 1'b0;
                    end
                end
                kmrd_pkg::FUNC_EXTRA:
                begin
                    if (!col_ok)
                    begin
                        out_ign_next = 1'b1;
                    end
                    else
                    begin
                        row_we         = 1'b1;
                        extra_row_next = in_press_reg ? (extra_reg[ridx] | col_bit)
                                                      : (extra_reg[ridx] & ~col_bit);
                    end
                end
                kmrd_pkg::FUNC_ONESHOT:
                begin
                    if (!col_ok)
                    begin
                        out_ign_next = 1'b1;
                    end
                    else
                    begin
                        row_we        = 1'b1;
                        shot_row_next = shot_reg[ridx] | col_bit;
                        pend_row_next = 1'b1;
                    end
                end
                default:
                begin
                    out_ign_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_high_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_high_reg <= cfg_data[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_func_reg  <= kmrd_pkg::func_t'(s_tuser);
            in_row_reg   <= s_tdata[3:0];
            in_col_reg   <= s_tdata[8:4];
            in_press_reg <= s_tdata[9];
            in_raw_reg   <= s_tdata[25:10];
        end
        if (adv)
        begin
            out_bits_reg <= out_bits_next;
            out_ign_reg  <= out_ign_next;
        end
    end

    // sample slots only count once written, so they need no reset
    always_ff @(posedge clk)
    begin
        if (adv && row_we)
        begin
            win_reg[ridx] <= win_row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                fill_reg[r]  <= '0;
                pos_reg[r]   <= '0;
                deb_reg[r]   <= '0;
                extra_reg[r] <= '0;
                shot_reg[r]  <= '0;
            end
            pend_reg <= '0;
        end
        else if (adv && row_we)
        begin
            fill_reg[ridx]  <= fill_row_next;
            pos_reg[ridx]   <= pos_row_next;
            deb_reg[ridx]   <= deb_row_next;
            extra_reg[ridx] <= extra_row_next;
            shot_reg[ridx]  <= shot_row_next;
            pend_reg[ridx]  <= pend_row_next;
        end
    end

`ifndef ASSERT_OFF
    a_ignored_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("ignored request carries nonzero row bits");

    a_bad_row_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !row_ok |=> m_tvalid && m_tuser[0])
        else $error("out-of-range row not flagged");

    a_read_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        adv && row_ok && in_func_reg == kmrd_pkg::FUNC_READ |=> !pend_reg[$past(ridx)])
        else $error("row read left one-shot keys pending");

    for (genvar r = 0; r < ROWS; r++)
    begin : g_chk
        a_pending_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
            pend_reg[r] == (shot_reg[r] != '0))
            else $error("one-shot pending flag out of step with its bits");

        a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
            fill_reg[r] <= FRAMES_FILL)
            else $error("window fill count past frame count");
    end
`endif

endmodule

`default_nettype wire
